// ----- rtl/ibh_pkg.sv -----
// shared types and constants for the indexed binary heap
// no dependencies
package ibh_pkg;
	localparam int Capacity = 1024;
	localparam int SlotW = 10;
	localparam int CountW = 11;
	localparam int RowW = 6;
	localparam int ColW = 6;
	localparam int PlaneW = 2;
	localparam int MapAw = PlaneW + RowW + ColW;
	localparam int KeyW = 32;
	localparam int CellW = RowW + ColW;

	localparam logic [1:0] FuncInsert = 2'd0;
	localparam logic [1:0] FuncChange = 2'd1;
	localparam logic [1:0] FuncExtract = 2'd2;

	localparam logic [1:0] StatOk = 2'd0;
	localparam logic [1:0] StatFull = 2'd1;
	localparam logic [1:0] StatEmpty = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAPRD,
		ST_MAPWAIT,
		ST_LOADCUR,
		ST_LOADWAIT,
		ST_UPRD,
		ST_UPCMP,
		ST_DNRDL,
		ST_DNRDR,
		ST_DNCMP,
		ST_DNSW2,
		ST_OUT
	} state_t;
endpackage

// ----- rtl/indexed_binary_heap_top.sv -----
// indexed binary heap: key/cell memories plus a cell-to-slot map memory
// sequencer does read-modify-write sifting; depends on ibh_pkg
// each level sifted up reads the parent and compares; each level down reads
// both children, compares and swaps; one operation at a time
// the key/cell memories have a single registered read port, which sets the rate
// reset clears the entry count, heap order and control; memories are not cleared
module indexed_binary_heap_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,        // heap_order
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,    // func, cell_row, cell_col, key, map_plane
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata     // out_row, out_col, out_slot, entry_total, status
);
	import ibh_pkg::*;

	logic [KeyW-1:0]   key_mem [Capacity];
	logic [CellW-1:0]  cell_mem [Capacity];
	logic [SlotW-1:0]  map_mem [1 << MapAw];

	state_t state_q, state_d;
	logic              order_q;
	logic [CountW-1:0] count_q;

	logic [1:0]        func_q;
	logic [CellW-1:0]  icell_q;
	logic [PlaneW-1:0] plane_q;

	logic [SlotW-1:0]  k_q;
	logic [KeyW-1:0]   ck_q;     // key of the moving entry (sign flipped)
	logic [CellW-1:0]  cc_q;
	logic [SlotW-1:0]  o_slot_q;
	logic [CellW-1:0]  o_cell_q;
	logic [1:0]        o_stat_q;
	logic [KeyW-1:0]   lk_q;
	logic [CellW-1:0]  lc_q;
	logic [SlotW-1:0]  c_q;

	logic              ovalid_q;
	logic [39:0]       odata_q;

	// memory ports
	logic [SlotW-1:0]  hr_addr;
	logic [KeyW-1:0]   hr_key;
	logic [CellW-1:0]  hr_cell;
	logic              hw_en;
	logic [SlotW-1:0]  hw_addr;
	logic [KeyW-1:0]   hw_key;
	logic [CellW-1:0]  hw_cell;
	logic [MapAw-1:0]  mr_addr;
	logic [SlotW-1:0]  mr_data;
	logic              mw_en;
	logic [MapAw-1:0]  mw_addr;
	logic [SlotW-1:0]  mw_data;

	always_ff @(posedge clk) begin
		if (hw_en) begin
			key_mem[hw_addr] <= hw_key;
			cell_mem[hw_addr] <= hw_cell;
		end
		hr_key <= key_mem[hr_addr];
		hr_cell <= cell_mem[hr_addr];
	end

	always_ff @(posedge clk) begin
		if (mw_en)
			map_mem[mw_addr] <= mw_data;
		mr_data <= map_mem[mr_addr];
	end

	function automatic logic above(input logic ord, input logic [KeyW-1:0] a,
			input logic [KeyW-1:0] b);
		above = ord ? (a > b) : (a < b);
	endfunction

	logic [CountW-1:0] l_idx, r_idx;
	logic [SlotW-1:0]  parent;
	logic              s_fire, m_fire;
	logic              r_better;
	logic              map_keep;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign parent = SlotW'((k_q - SlotW'(1)) >> 1);
	assign l_idx = {k_q, 1'b1};
	assign r_idx = l_idx + CountW'(1);
	assign r_better = !above(order_q, lk_q, hr_key);
	// a change that leaves its entry in place does not touch the map
	assign map_keep = (func_q == FuncChange) && (k_q == o_slot_q);

	logic [SlotW-1:0] k_d, c_d, o_slot_d;
	logic [KeyW-1:0]  ck_d, lk_d;
	logic [CellW-1:0] cc_d, lc_d, o_cell_d;
	logic [1:0]       o_stat_d;
	logic [CountW-1:0] count_d;
	logic             emit;

	always_comb begin
		state_d = state_q;
		k_d = k_q; c_d = c_q; ck_d = ck_q; cc_d = cc_q; lk_d = lk_q; lc_d = lc_q;
		o_slot_d = o_slot_q; o_cell_d = o_cell_q; o_stat_d = o_stat_q;
		count_d = count_q;
		emit = 1'b0;
		hr_addr = k_q;
		hw_en = 1'b0; hw_addr = k_q; hw_key = ck_q; hw_cell = cc_q;
		mr_addr = {plane_q, icell_q};
		mw_en = 1'b0; mw_addr = {plane_q, cc_q}; mw_data = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					o_cell_d = s_axis_tdata[13:2];
					o_slot_d = '0;
					o_stat_d = StatOk;
					ck_d = s_axis_tdata[45:14] ^ {1'b1, {(KeyW-1){1'b0}}};
					cc_d = s_axis_tdata[13:2];
					mr_addr = {s_axis_tdata[47:46], s_axis_tdata[13:2]};
					hr_addr = '0;
					k_d = '0;
					case (s_axis_tdata[1:0])
						FuncInsert: begin
							if (count_q >= CountW'(Capacity)) begin
								o_stat_d = StatFull;
								state_d = ST_OUT;
							end else begin
								k_d = SlotW'(count_q);
								count_d = count_q + CountW'(1);
								state_d = ST_UPRD;
							end
						end
						FuncChange: state_d = ST_MAPWAIT;
						FuncExtract: begin
							if (count_q == '0) begin
								o_cell_d = '0;
								o_stat_d = StatEmpty;
								state_d = ST_OUT;
							end else begin
								count_d = count_q - CountW'(1);
								state_d = ST_LOADCUR;
							end
						end
						default: begin
							o_cell_d = '0;
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_MAPWAIT: begin
				k_d = mr_data;
				o_slot_d = mr_data;
				if ({1'b0, mr_data} < count_q) begin
					hw_en = 1'b1; hw_addr = mr_data; hw_key = ck_q; hw_cell = icell_q;
					cc_d = icell_q;
					// keep stored cell: read it back for the moving entry
					hr_addr = mr_data;
					state_d = ST_MAPRD;
				end else
					state_d = ST_OUT;
			end
			ST_MAPRD: begin
				// read was issued with the write; hr_cell holds the old cell
				cc_d = hr_cell;
				hw_en = 1'b1; hw_addr = k_q; hw_key = ck_q; hw_cell = hr_cell;
				state_d = ST_UPRD;
			end
			ST_LOADCUR: begin
				// root cell is now on the read port; fetch the last entry
				o_cell_d = hr_cell;
				hr_addr = SlotW'(count_q);
				state_d = ST_LOADWAIT;
			end
			ST_LOADWAIT: begin
				if (count_q == '0)
					state_d = ST_OUT;
				else begin
					ck_d = hr_key; cc_d = hr_cell;
					k_d = '0;
					state_d = ST_DNRDL;
				end
			end
			ST_UPRD: begin
				if (k_q == '0)
					state_d = ST_DNRDL;
				else begin
					hr_addr = parent;
					state_d = ST_UPCMP;
				end
			end
			ST_UPCMP: begin
				if (above(order_q, ck_q, hr_key)) begin
					// parent moves down into k
					hw_en = 1'b1; hw_addr = k_q; hw_key = hr_key; hw_cell = hr_cell;
					mw_en = 1'b1; mw_addr = {plane_q, hr_cell}; mw_data = k_q;
					k_d = parent;
					state_d = ST_UPRD;
				end else
					state_d = ST_DNRDL;
			end
			ST_DNRDL: begin
				if (l_idx >= count_q) begin
					hw_en = 1'b1;
					mw_en = !map_keep;
					state_d = ST_OUT;
				end else begin
					hr_addr = SlotW'(l_idx);
					state_d = ST_DNRDR;
				end
			end
			ST_DNRDR: begin
				lk_d = hr_key; lc_d = hr_cell;
				hr_addr = SlotW'(r_idx);
				state_d = ST_DNCMP;
			end
			ST_DNCMP: begin
				if (r_idx < count_q && r_better) begin
					lk_d = hr_key; lc_d = hr_cell; c_d = SlotW'(r_idx);
				end else
					c_d = SlotW'(l_idx);
				state_d = ST_DNSW2;
			end
			ST_DNSW2: begin
				if (above(order_q, lk_q, ck_q)) begin
					hw_en = 1'b1; hw_key = lk_q; hw_cell = lc_q;
					mw_en = 1'b1; mw_addr = {plane_q, lc_q}; mw_data = k_q;
					k_d = c_q;
					state_d = ST_DNRDL;
				end else begin
					hw_en = 1'b1;
					mw_en = !map_keep;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ovalid_q || m_fire) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// final slot of the moving entry
		if (state_q == ST_DNRDL && l_idx >= count_q && func_q != FuncExtract)
			o_slot_d = k_q;
		if (state_q == ST_DNSW2 && !above(order_q, lk_q, ck_q) && func_q != FuncExtract)
			o_slot_d = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= 1'b0;
			count_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid && cfg_ready)
				order_q <= cfg_data;
			if (emit)
				ovalid_q <= 1'b1;
			else if (m_fire)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d; c_q <= c_d; ck_q <= ck_d; cc_q <= cc_d; lk_q <= lk_d; lc_q <= lc_d;
		o_slot_q <= o_slot_d; o_cell_q <= o_cell_d; o_stat_q <= o_stat_d;
		if (s_fire) begin
			func_q <= s_axis_tdata[1:0];
			icell_q <= s_axis_tdata[13:2];
			plane_q <= s_axis_tdata[47:46];
		end
		if (emit)
			odata_q <= {5'b00000, o_stat_q, count_q, o_slot_q, o_cell_q};
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Capacity)) else $error("entry count above capacity");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !s_fire |=> $stable(count_q)) else $error("count moved while idle");
`endif
endmodule
